[sv/sakv_pkg.sv]
`default_nettype none
package sakv_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int KEY_W = 32;
  localparam int DATA_W = 32;
  localparam int STAMP_W = 32;

  localparam logic [1:0] FUNC_PUT = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_SET_ALL = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [KEY_W-1:0] key;
    logic [DATA_W-1:0] data;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic found;
    logic [DATA_W-1:0] data;
  } rsp_t;

endpackage
`default_nettype wire

[sv/sakv_match.sv]
`default_nettype none
module sakv_match #(
  parameter int ENTRIES = sakv_pkg::ENTRIES_DEF,
  parameter int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic [ENTRIES-1:0] valid,
  input  wire logic [ENTRIES-1:0][sakv_pkg::KEY_W-1:0] keys,
  input  wire logic [sakv_pkg::KEY_W-1:0] key,
  output logic hit_any,
  output logic [IDX_W-1:0] hit_idx,
  output logic free_any,
  output logic [IDX_W-1:0] free_idx
);
  import sakv_pkg::*;

  logic [ENTRIES-1:0] hit;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit[i] = valid[i] && (keys[i] == key);
    end
  end

  // lowest slot wins
  always_comb begin
    hit_idx = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!valid[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    hit_any = |hit;
    free_any = ~&valid;
  end

endmodule
`default_nettype wire

[sv/sakv_table.sv]
`default_nettype none
module sakv_table #(
  parameter int ENTRIES = sakv_pkg::ENTRIES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  input  wire sakv_pkg::req_t req,
  output sakv_pkg::rsp_t rsp
);
  import sakv_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [ENTRIES-1:0] entry_valid;
  logic [ENTRIES-1:0][KEY_W-1:0] entry_key;
  logic [ENTRIES-1:0][DATA_W-1:0] entry_data;
  logic [ENTRIES-1:0][STAMP_W-1:0] entry_stamp;
  logic [DATA_W-1:0] global_data;
  logic [STAMP_W-1:0] global_stamp;
  logic [STAMP_W-1:0] stamp_counter;

  logic hit_any;
  logic free_any;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] free_idx;

  logic exhausted;
  logic wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic set_all;

  sakv_match #(
    .ENTRIES(ENTRIES),
    .IDX_W(IDX_W)
  ) u_match (
    .valid(entry_valid),
    .keys(entry_key),
    .key(req.key),
    .hit_any(hit_any),
    .hit_idx(hit_idx),
    .free_any(free_any),
    .free_idx(free_idx)
  );

  assign exhausted = (stamp_counter == '0);

  always_comb begin
    rsp = '0;
    wr_en = 1'b0;
    wr_idx = hit_idx;
    set_all = 1'b0;
    if (req_valid) begin
      case (req.func)
        FUNC_PUT: begin
          if (exhausted) begin
            rsp.status = ST_EXHAUSTED;
          end else if (hit_any) begin
            wr_en = 1'b1;
          end else if (free_any) begin
            wr_en = 1'b1;
            wr_idx = free_idx;
          end else begin
            rsp.status = ST_FULL;
          end
        end
        FUNC_LOOKUP: begin
          if (hit_any) begin
            rsp.found = 1'b1;
            rsp.data = (entry_stamp[hit_idx] > global_stamp) ? entry_data[hit_idx]
                                                             : global_data;
          end else begin
            rsp.status = ST_MISSING;
          end
        end
        FUNC_SET_ALL: begin
          if (exhausted) begin
            rsp.status = ST_EXHAUSTED;
          end else begin
            set_all = 1'b1;
          end
        end
        default: begin
          rsp = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      global_data <= '0;
      global_stamp <= '0;
      stamp_counter <= STAMP_W'(1);
    end else begin
      if (wr_en) begin
        entry_valid[wr_idx] <= 1'b1;
      end
      if (set_all) begin
        global_data <= req.data;
        global_stamp <= stamp_counter;
      end
      if (wr_en || set_all) begin
        stamp_counter <= stamp_counter + STAMP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_key[wr_idx] <= req.key;
      entry_data[wr_idx] <= req.data;
      entry_stamp[wr_idx] <= stamp_counter;
    end
  end

endmodule
`default_nettype wire

[sv/set_all_key_value_table.sv]
// Channel   Ports                          Handshake
// request   func, key, data_in             start high while busy low
// result    status, found, data_out        done high for one cycle
//
// One request per cycle; busy stays low.
// A result follows its request through the input register, then the result register.
// The table is updated at the same edge that loads the result, so the next request sees it.
// rst is synchronous: clears valid bits, set-all value and stamp, stamp counter to one.
// The receiver cannot stall; results are never held back.
`default_nettype none
module set_all_key_value_table #(
  parameter int ENTRIES = sakv_pkg::ENTRIES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic [1:0] func,
  input  wire logic signed [sakv_pkg::KEY_W-1:0] key,
  input  wire logic signed [sakv_pkg::DATA_W-1:0] data_in,
  output logic done,
  output logic [1:0] status,
  output logic found,
  output logic signed [sakv_pkg::DATA_W-1:0] data_out
);
  import sakv_pkg::*;

  logic req_valid;
  req_t req;
  rsp_t rsp;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    req.func <= func;
    req.key <= key;
    req.data <= data_in;
  end

  sakv_table #(
    .ENTRIES(ENTRIES)
  ) u_table (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req(req),
    .rsp(rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      status <= ST_OK;
      found <= 1'b0;
      data_out <= '0;
    end else begin
      done <= req_valid;
      status <= rsp.status;
      found <= rsp.found;
      data_out <= rsp.data;
    end
  end

`ifndef ASSERT_OFF
  a_done_follows_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 2))
    else $error("result without request");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    found |-> (done && status == ST_OK))
    else $error("found with bad status or no strobe");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (status != ST_OK) |-> (done && !found && data_out == '0))
    else $error("error result carries data");
`endif

endmodule
`default_nettype wire
